/* rtl/midpoint_ellipse_rasterizer_top_defines.svh */
// Assertion macros for the rasterizer checker file.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define MER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mer_pkg.sv */
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    localparam int POINT_W = 14;
    localparam int QUAD_W  = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] REGION_DONE = 2'd0;
    localparam logic [1:0] REGION_ONE  = 2'd1;
    localparam logic [1:0] REGION_TWO  = 2'd2;

    localparam logic [QUAD_W-1:0] QUAD_LAST = 2'd3;

    // Operation of the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE = 4'd0,
        MUL_AA   = 4'd1,
        MUL_BB   = 4'd2,
        MUL_A2B  = 4'd3,
        MUL_A2B2 = 4'd4,
        MUL_TX2  = 4'd5,
        MUL_BTX  = 4'd6,
        MUL_TY2  = 4'd7,
        MUL_ATY  = 4'd8
    } mul_op_t;

    typedef struct packed {
        logic              load;
        mul_op_t           mul_op;
        logic              init_dec;
        logic              r2_set;
        logic              advance;
        logic              dec_update;
        logic              emit;
        logic [QUAD_W-1:0] quad;
    } cmd_t;

    typedef struct packed {
        logic [1:0] region;
        logic       dx_lt_dy;
        logic       out_free;
    } status_t;

endpackage

/* rtl/midpoint_ellipse_rasterizer_top.sv */
// Top level of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

// A start item (opcode 0) latches the centre and both semi-axes and returns
// nothing; it occupies the block while one shared multiplier forms a*a,
// b*b, a*a*b and a*a*b*b, one product per cycle. Each step item (opcode 1)
// returns four mirrored points in quadrant order 0, 1, 2, 3, the final
// point of the ellipse flagged by last. A step is one walk update, one
// decision update and four points through the single output register, and
// the block takes no new item until its last point is loaded. The step that
// crosses from region one to region two first runs the four chained
// multiplies of the region-two decision. A step after the walk is done is
// accepted and returns nothing. Points are centre plus or minus offset,
// wrapped to 14 bits.
module midpoint_ellipse_rasterizer_top #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [COORD_BITS-1:0]               center_x,
    input  logic [COORD_BITS-1:0]               center_y,
    input  logic [RADIUS_BITS-1:0]              radius_x,
    input  logic [RADIUS_BITS-1:0]              radius_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mer_pkg::POINT_W-1:0]  point_x,
    output logic signed [mer_pkg::POINT_W-1:0]  point_y,
    output logic [mer_pkg::QUAD_W-1:0]          quadrant,
    output logic                                last
);

    mer_pkg::cmd_t    cmd;
    mer_pkg::status_t status;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mer_datapath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius_x  (radius_x),
        .radius_y  (radius_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .quadrant  (quadrant),
        .last      (last)
    );

endmodule

/* rtl/mer_ctrl.sv */
// Controller state machine: sequences start set-up, region switch, update and point emission.
`timescale 1ns / 1ps

module mer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             opcode,
    input  mer_pkg::status_t status,
    output logic             in_ready,
    output mer_pkg::cmd_t    cmd
);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_AA    = 14'b00000000000010,
        ST_BB    = 14'b00000000000100,
        ST_A2B   = 14'b00000000001000,
        ST_A2B2  = 14'b00000000010000,
        ST_INIT  = 14'b00000000100000,
        ST_TX2   = 14'b00000001000000,
        ST_BTX   = 14'b00000010000000,
        ST_TY2   = 14'b00000100000000,
        ST_ATY   = 14'b00001000000000,
        ST_R2SET = 14'b00010000000000,
        ST_ADV   = 14'b00100000000000,
        ST_DEC   = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } ctrl_state_t;

    ctrl_state_t                 state_reg;
    ctrl_state_t                 state_next;
    logic [mer_pkg::QUAD_W-1:0]  quad_reg;
    logic [mer_pkg::QUAD_W-1:0]  quad_next;
    logic                        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        quad_next      = quad_reg;
        cmd            = '0;
        cmd.mul_op     = mer_pkg::MUL_NONE;
        cmd.quad       = quad_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == mer_pkg::OP_START)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_AA;
                    end
                    else if (status.region == mer_pkg::REGION_ONE && !status.dx_lt_dy)
                    begin
                        state_next = ST_TX2;
                    end
                    else if (status.region != mer_pkg::REGION_DONE)
                    begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_AA:
            begin
                cmd.mul_op = mer_pkg::MUL_AA;
                state_next = ST_BB;
            end
            ST_BB:
            begin
                cmd.mul_op = mer_pkg::MUL_BB;
                state_next = ST_A2B;
            end
            ST_A2B:
            begin
                cmd.mul_op = mer_pkg::MUL_A2B;
                state_next = ST_A2B2;
            end
            ST_A2B2:
            begin
                cmd.mul_op = mer_pkg::MUL_A2B2;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init_dec = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_TX2:
            begin
                cmd.mul_op = mer_pkg::MUL_TX2;
                state_next = ST_BTX;
            end
            ST_BTX:
            begin
                cmd.mul_op = mer_pkg::MUL_BTX;
                state_next = ST_TY2;
            end
            ST_TY2:
            begin
                cmd.mul_op = mer_pkg::MUL_TY2;
                state_next = ST_ATY;
            end
            ST_ATY:
            begin
                cmd.mul_op = mer_pkg::MUL_ATY;
                state_next = ST_R2SET;
            end
            ST_R2SET:
            begin
                cmd.r2_set = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.dec_update = 1'b1;
                quad_next      = '0;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Load one point whenever the output register frees up
                if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    quad_next = quad_reg + 1'b1;
                    if (quad_reg == mer_pkg::QUAD_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            quad_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            quad_reg  <= quad_next;
        end
    end

endmodule

/* rtl/mer_datapath.sv */
// Datapath: held ellipse, walk registers, shared multiplier and output register.
`timescale 1ns / 1ps

module mer_datapath #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mer_pkg::cmd_t                       cmd,
    output mer_pkg::status_t                    status,
    input  logic [COORD_BITS-1:0]               center_x,
    input  logic [COORD_BITS-1:0]               center_y,
    input  logic [RADIUS_BITS-1:0]              radius_x,
    input  logic [RADIUS_BITS-1:0]              radius_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mer_pkg::POINT_W-1:0]  point_x,
    output logic signed [mer_pkg::POINT_W-1:0]  point_y,
    output logic [mer_pkg::QUAD_W-1:0]          quadrant,
    output logic                                last
);

    localparam int X_W   = RADIUS_BITS + 1;
    localparam int Y_W   = RADIUS_BITS + 2;
    localparam int SQ_W  = 2 * RADIUS_BITS;
    localparam int CU_W  = 3 * RADIUS_BITS;
    localparam int QU_W  = 4 * RADIUS_BITS;
    localparam int SD_W  = 3 * RADIUS_BITS + 4;
    localparam int DEC_W = 4 * RADIUS_BITS + 6;
    localparam int MUL_W = 2 * RADIUS_BITS + 4;
    localparam int PRD_W = 2 * MUL_W;
    localparam int T_W   = 2 * RADIUS_BITS + 4;
    localparam int U_W   = 4 * RADIUS_BITS + 4;
    localparam int PW    = mer_pkg::POINT_W;

    // Held ellipse and derived products
    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [RADIUS_BITS-1:0] a_reg, b_reg;
    logic [SQ_W-1:0]        a2_reg, b2_reg;
    logic [CU_W-1:0]        a2b_reg;
    logic [QU_W-1:0]        a2b2_reg;
    logic [T_W-1:0]         t_reg;
    logic [DEC_W-1:0]       acc_reg;
    logic [U_W-1:0]         u_reg;

    // Walk state
    logic [1:0]             region_reg, region_next;
    logic [X_W-1:0]         x_reg;
    logic [Y_W-1:0]         y_reg;
    logic [SD_W-1:0]        dx_reg, dy_reg;
    logic [DEC_W-1:0]       dec_reg;
    logic [X_W-1:0]         pt_x_reg;
    logic [Y_W-1:0]         pt_y_reg;
    logic                   last_reg;
    logic                   step_x_reg, step_y_reg, r1_reg;

    // Output register
    logic                   out_valid_reg;
    logic [PW-1:0]          out_x_reg, out_y_reg;
    logic [mer_pkg::QUAD_W-1:0] out_q_reg;
    logic                   out_last_reg;

    logic [MUL_W-1:0]       op_a, op_b;
    logic [PRD_W-1:0]       prod;
    logic [X_W:0]           tx;
    logic [Y_W-1:0]         ty_abs;
    logic                   dec_neg, dec_pos;
    logic                   step_x, step_y;
    logic [X_W-1:0]         x_new;
    logic [Y_W-1:0]         y_new;
    logic [SD_W-1:0]        dx_new, dy_new;
    logic [DEC_W-1:0]       dec_term;
    logic [PW-1:0]          px, py, ex, ey;

    assign tx     = {x_reg, 1'b1};
    assign ty_abs = (y_reg == '0) ? Y_W'(1) : y_reg - 1'b1;

    always_comb
    begin
        case (cmd.mul_op)
            mer_pkg::MUL_AA:
            begin
                op_a = MUL_W'(a_reg);
                op_b = MUL_W'(a_reg);
            end
            mer_pkg::MUL_BB:
            begin
                op_a = MUL_W'(b_reg);
                op_b = MUL_W'(b_reg);
            end
            mer_pkg::MUL_A2B:
            begin
                op_a = MUL_W'(a2_reg);
                op_b = MUL_W'(b_reg);
            end
            mer_pkg::MUL_A2B2:
            begin
                op_a = MUL_W'(a2_reg);
                op_b = MUL_W'(b2_reg);
            end
            mer_pkg::MUL_TX2:
            begin
                op_a = MUL_W'(tx);
                op_b = MUL_W'(tx);
            end
            mer_pkg::MUL_BTX:
            begin
                op_a = MUL_W'(b2_reg);
                op_b = MUL_W'(t_reg);
            end
            mer_pkg::MUL_TY2:
            begin
                op_a = MUL_W'(ty_abs);
                op_b = MUL_W'(ty_abs);
            end
            mer_pkg::MUL_ATY:
            begin
                op_a = MUL_W'(a2_reg);
                op_b = MUL_W'(t_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = PRD_W'(op_a) * PRD_W'(op_b);

    // Walk update: region one always steps x, region two always steps y
    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);
    assign step_x  = (region_reg == mer_pkg::REGION_ONE) ? 1'b1 : !dec_pos;
    assign step_y  = (region_reg == mer_pkg::REGION_ONE) ? !dec_neg : 1'b1;
    assign x_new   = step_x ? x_reg + 1'b1 : x_reg;
    assign y_new   = step_y ? y_reg - 1'b1 : y_reg;
    assign dx_new  = step_x ? dx_reg + SD_W'({b2_reg, 1'b0}) : dx_reg;
    assign dy_new  = step_y ? dy_reg - SD_W'({a2_reg, 1'b0}) : dy_reg;

    always_comb
    begin
        region_next = region_reg;
        if (cmd.load)
        begin
            region_next = mer_pkg::REGION_ONE;
        end
        else if (cmd.r2_set)
        begin
            region_next = mer_pkg::REGION_TWO;
        end
        else if (cmd.advance && region_reg == mer_pkg::REGION_TWO && y_new[Y_W-1])
        begin
            region_next = mer_pkg::REGION_DONE;
        end
    end

    // Decision increment from the already advanced gradients
    assign dec_term = (step_x_reg ? DEC_W'(dx_reg) : '0)
                    - (step_y_reg ? DEC_W'(dy_reg) : '0)
                    + (r1_reg ? DEC_W'(b2_reg) : DEC_W'(a2_reg));

    assign px = PW'(pt_x_reg);
    assign py = PW'(pt_y_reg);
    assign ex = PW'(cx_reg) + (cmd.quad[0] ? -px : px);
    assign ey = PW'(cy_reg) + (cmd.quad[1] ? -py : py);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            a_reg  <= radius_x;
            b_reg  <= radius_y;
            x_reg  <= '0;
            y_reg  <= Y_W'(radius_y);
            dx_reg <= '0;
        end
        case (cmd.mul_op)
            mer_pkg::MUL_AA:   a2_reg   <= SQ_W'(prod);
            mer_pkg::MUL_BB:   b2_reg   <= SQ_W'(prod);
            mer_pkg::MUL_A2B:  a2b_reg  <= CU_W'(prod);
            mer_pkg::MUL_A2B2: a2b2_reg <= QU_W'(prod);
            mer_pkg::MUL_TX2:  t_reg    <= T_W'(prod);
            mer_pkg::MUL_BTX:  acc_reg  <= DEC_W'(prod);
            mer_pkg::MUL_TY2:  t_reg    <= T_W'(prod);
            mer_pkg::MUL_ATY:  u_reg    <= U_W'(prod);
            default:
            begin
            end
        endcase
        if (cmd.init_dec)
        begin
            dy_reg  <= SD_W'({a2b_reg, 1'b0});
            dec_reg <= DEC_W'({b2_reg, 2'b00}) - DEC_W'({a2b_reg, 2'b00}) + DEC_W'(a2_reg);
        end
        if (cmd.r2_set)
        begin
            dec_reg <= acc_reg + DEC_W'({u_reg, 2'b00}) - DEC_W'({a2b2_reg, 2'b00});
        end
        if (cmd.advance)
        begin
            pt_x_reg   <= x_reg;
            pt_y_reg   <= y_reg;
            x_reg      <= x_new;
            y_reg      <= y_new;
            dx_reg     <= dx_new;
            dy_reg     <= dy_new;
            step_x_reg <= step_x;
            step_y_reg <= step_y;
            r1_reg     <= (region_reg == mer_pkg::REGION_ONE);
            last_reg   <= (region_reg == mer_pkg::REGION_TWO) && y_new[Y_W-1];
        end
        if (cmd.dec_update)
        begin
            dec_reg <= dec_reg + {dec_term[DEC_W-3:0], 2'b00};
        end
        if (cmd.emit)
        begin
            out_x_reg    <= ex;
            out_y_reg    <= ey;
            out_q_reg    <= cmd.quad;
            out_last_reg <= last_reg && (cmd.quad == mer_pkg::QUAD_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg    <= mer_pkg::REGION_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            region_reg <= region_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.region   = region_reg;
    assign status.dx_lt_dy = (dx_reg < dy_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign point_x   = $signed(out_x_reg);
    assign point_y   = $signed(out_y_reg);
    assign quadrant  = out_q_reg;
    assign last      = out_last_reg;

endmodule

/* rtl/mer_checker.sv */
// Port-level checker for the rasterizer and its bind to the top level.
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_top_defines.svh"

module mer_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [mer_pkg::POINT_W-1:0]  point_x,
    input logic signed [mer_pkg::POINT_W-1:0]  point_y,
    input logic [mer_pkg::QUAD_W-1:0]          quadrant,
    input logic                                last
);

    `MER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(quadrant) && $stable(last), "stalled output item changed")

    `MER_ASSERT_NOW(a_last_on_q3, out_valid && quadrant != mer_pkg::QUAD_LAST, !last, "last flag on a point before quadrant 3")

    `MER_ASSERT_NEXT(a_quad_seq, out_valid && out_ready && quadrant != mer_pkg::QUAD_LAST, out_valid && quadrant == $past(quadrant) + 2'd1, "mirrored points not back to back in order")

    `MER_ASSERT_NOW(a_busy_in_step, out_valid && quadrant != mer_pkg::QUAD_LAST, !in_ready, "input taken in the middle of a step")

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .quadrant  (quadrant),
    .last      (last)
);
